// ===== hw/rtl/ssst_pkg.sv =====
// ----------------------------------------------------------------------------
// ssst_pkg - shared types and constants of the sample slot table
// Holds the function codes, controller states and the command word that
// the controller broadcasts to every slot cell.
// ----------------------------------------------------------------------------
package ssst_pkg;

	// Width of a decoded time of day in seconds (the largest undecoded
	// pattern gives 165*3600 + 165*60 + 165, which fits in 20 bits).
	localparam int SEC_W = 20;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_ACK    = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;
	localparam logic [1:0] FUNC_QUERY  = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_START1,
		S_WAIT1,
		S_APPLY,
		S_START2,
		S_WAIT2,
		S_DONE
	} state_t;

	// Command broadcast to all cells; the selected cell applies it, but a clear-all applies in every cell.
	typedef struct packed {
		logic             load_secs;
		logic             use_val;
		logic             clr_all;
		logic [SEC_W-1:0] secs;
	} cmd_t;

endpackage

// ===== hw/rtl/timestamped_sample_slot_table_top.sv =====
// ----------------------------------------------------------------------------
// timestamped_sample_slot_table_top - oldest-entry replacement slot table
// A table of SLOT_COUNT time-stamped slots kept in a row of cells. Each
// input word carries a function (insert, acknowledge by time, clear, query)
// and a BCD time of day; each produces exactly one result word giving the
// slot touched, the acknowledge hit flag, the newest and oldest in-use
// slots and the in-use and replaceable counts after the step. An item runs
// two scans down the cell row, one cell per cycle: the first finds the
// insert or acknowledge target, the second gathers the report once the
// update is written. One item is in flight at a time, and the next word
// is taken as soon as the result sits in the output register.
// ----------------------------------------------------------------------------
module timestamped_sample_slot_table_top #(
	parameter int SLOT_COUNT = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] hour_bcd,
	input  logic [7:0] minute_bcd,
	input  logic [7:0] second_bcd,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] slot_index,
	output logic       ack_hit,
	output logic [2:0] newest_slot,
	output logic [2:0] oldest_slot,
	output logic       any_in_use,
	output logic [3:0] in_use_count,
	output logic [3:0] replaceable_count
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int SEC_W = ssst_pkg::SEC_W;

	// Decodes one BCD digit pair without checking the digits.
	function automatic logic [7:0] bcd_pair(input logic [7:0] v);
		logic [7:0] hi;
		hi = {4'd0, v[7:4]};
		return (hi * 8'd10) + {4'd0, v[3:0]};
	endfunction

	ssst_pkg::state_t state_q, state_d;

	logic [1:0]             func_q;
	logic [7:0]             hour_q, minute_q, second_q;
	logic [SEC_W-1:0]       want_q;
	logic [SEC_W-1:0]       want_d;
	logic [IDX_W-1:0]       index_q;
	logic                   hit_q;

	logic                   out_valid_q;
	logic [2:0]             slot_index_q, newest_q, oldest_q;
	logic                   ack_hit_q, any_q;
	logic [3:0]             in_use_cnt_q, repl_cnt_q;

	// Scan chain; element 0 is fed by the controller, the last is the tail.
	logic                   c_vld         [SLOT_COUNT+1];
	logic                   c_free_found  [SLOT_COUNT+1];
	logic [IDX_W-1:0]       c_free_idx    [SLOT_COUNT+1];
	logic                   c_min_found   [SLOT_COUNT+1];
	logic [IDX_W-1:0]       c_min_idx     [SLOT_COUNT+1];
	logic [SEC_W-1:0]       c_min_val     [SLOT_COUNT+1];
	logic                   c_max_found   [SLOT_COUNT+1];
	logic [IDX_W-1:0]       c_max_idx     [SLOT_COUNT+1];
	logic [SEC_W-1:0]       c_max_val     [SLOT_COUNT+1];
	logic                   c_match_found [SLOT_COUNT+1];
	logic [IDX_W-1:0]       c_match_idx   [SLOT_COUNT+1];
	logic [CNT_W-1:0]       c_count       [SLOT_COUNT+1];

	logic                   start;
	logic                   wr;
	logic [IDX_W-1:0]       wr_target;
	logic [IDX_W-1:0]       ins_target;
	ssst_pkg::cmd_t         cmd;
	logic                   load_out;
	logic                   tail_vld;
	logic [SLOT_COUNT-1:0]  sel;

	assign tail_vld = c_vld[SLOT_COUNT];

	// The seed word entering the first cell: nothing found yet.
	always_comb begin
		c_vld[0]         = start;
		c_free_found[0]  = 1'b0;
		c_free_idx[0]    = '0;
		c_min_found[0]   = 1'b0;
		c_min_idx[0]     = '0;
		c_min_val[0]     = '0;
		c_max_found[0]   = 1'b0;
		c_max_idx[0]     = '0;
		c_max_val[0]     = '0;
		c_match_found[0] = 1'b0;
		c_match_idx[0]   = '0;
		c_count[0]       = '0;
	end

	genvar gi;
	generate
		for (gi = 0; gi < SLOT_COUNT; gi++) begin : g_cell
			assign sel[gi] = wr && (wr_target == IDX_W'(gi));

			ssst_cell #(
				.IDX_W    (IDX_W),
				.CNT_W    (CNT_W),
				.CELL_IDX (gi)
			) u_cell (
				.clk              (clk),
				.arst_n           (arst_n),
				.sel              (sel[gi]),
				.cmd              (cmd),
				.prev_vld         (c_vld[gi]),
				.prev_free_found  (c_free_found[gi]),
				.prev_free_idx    (c_free_idx[gi]),
				.prev_min_found   (c_min_found[gi]),
				.prev_min_idx     (c_min_idx[gi]),
				.prev_min_val     (c_min_val[gi]),
				.prev_max_found   (c_max_found[gi]),
				.prev_max_idx     (c_max_idx[gi]),
				.prev_max_val     (c_max_val[gi]),
				.prev_match_found (c_match_found[gi]),
				.prev_match_idx   (c_match_idx[gi]),
				.prev_count       (c_count[gi]),
				.next_vld         (c_vld[gi+1]),
				.next_free_found  (c_free_found[gi+1]),
				.next_free_idx    (c_free_idx[gi+1]),
				.next_min_found   (c_min_found[gi+1]),
				.next_min_idx     (c_min_idx[gi+1]),
				.next_min_val     (c_min_val[gi+1]),
				.next_max_found   (c_max_found[gi+1]),
				.next_max_idx     (c_max_idx[gi+1]),
				.next_max_val     (c_max_val[gi+1]),
				.next_match_found (c_match_found[gi+1]),
				.next_match_idx   (c_match_idx[gi+1]),
				.next_count       (c_count[gi+1])
			);
		end
	endgenerate

	// Seconds of the captured time, registered in the conversion cycle.
	always_comb begin
		want_d = (SEC_W'(bcd_pair(hour_q)) * SEC_W'(3600))
		       + (SEC_W'(bcd_pair(minute_q)) * SEC_W'(60))
		       + SEC_W'(bcd_pair(second_q));
	end

	// Insert goes to the first replaceable slot, else to the oldest in use.
	// With no replaceable slot every slot is in use, so the oldest exists.
	always_comb begin
		if (c_free_found[SLOT_COUNT]) begin
			ins_target = c_free_idx[SLOT_COUNT];
		end else if (c_min_found[SLOT_COUNT]) begin
			ins_target = c_min_idx[SLOT_COUNT];
		end else begin
			ins_target = '0;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ssst_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = ssst_pkg::S_CONV;
				end
			end
			ssst_pkg::S_CONV:   state_d = ssst_pkg::S_START1;
			ssst_pkg::S_START1: state_d = ssst_pkg::S_WAIT1;
			ssst_pkg::S_WAIT1: begin
				if (tail_vld) begin
					state_d = ssst_pkg::S_APPLY;
				end
			end
			ssst_pkg::S_APPLY:  state_d = ssst_pkg::S_START2;
			ssst_pkg::S_START2: state_d = ssst_pkg::S_WAIT2;
			ssst_pkg::S_WAIT2: begin
				if (tail_vld) begin
					state_d = ssst_pkg::S_DONE;
				end
			end
			ssst_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ssst_pkg::S_IDLE;
				end
			end
			default: state_d = ssst_pkg::S_IDLE;
		endcase
	end

	// Controller outputs: handshake, scan start and the slot update.
	always_comb begin
		in_ready      = 1'b0;
		start         = 1'b0;
		wr            = 1'b0;
		wr_target     = '0;
		load_out      = 1'b0;
		cmd.load_secs = 1'b0;
		cmd.use_val   = 1'b0;
		cmd.clr_all   = 1'b0;
		cmd.secs      = want_q;
		unique case (state_q)
			ssst_pkg::S_IDLE:   in_ready = 1'b1;
			ssst_pkg::S_START1: start    = 1'b1;
			ssst_pkg::S_START2: start    = 1'b1;
			ssst_pkg::S_APPLY: begin
				unique case (func_q)
					ssst_pkg::FUNC_INSERT: begin
						wr            = 1'b1;
						wr_target     = ins_target;
						cmd.load_secs = 1'b1;
						cmd.use_val   = 1'b1;
					end
					ssst_pkg::FUNC_ACK: begin
						// Only the mark changes; the stored time is kept.
						wr        = c_match_found[SLOT_COUNT];
						wr_target = c_match_idx[SLOT_COUNT];
					end
					ssst_pkg::FUNC_CLEAR: cmd.clr_all = 1'b1;
					default: ;
				endcase
			end
			ssst_pkg::S_DONE:   load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssst_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q   <= func;
			hour_q   <= hour_bcd;
			minute_q <= minute_bcd;
			second_q <= second_bcd;
		end
		if (state_q == ssst_pkg::S_CONV) begin
			want_q <= want_d;
		end
		if (state_q == ssst_pkg::S_APPLY) begin
			if (func_q == ssst_pkg::FUNC_INSERT) begin
				index_q <= ins_target;
				hit_q   <= 1'b0;
			end else if ((func_q == ssst_pkg::FUNC_ACK) && c_match_found[SLOT_COUNT]) begin
				index_q <= c_match_idx[SLOT_COUNT];
				hit_q   <= 1'b1;
			end else begin
				index_q <= '0;
				hit_q   <= 1'b0;
			end
		end
	end

	// Output register; the result word waits here until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			slot_index_q <= 3'(index_q);
			ack_hit_q    <= hit_q;
			newest_q     <= c_max_found[SLOT_COUNT] ? 3'(c_max_idx[SLOT_COUNT]) : 3'd0;
			oldest_q     <= c_min_found[SLOT_COUNT] ? 3'(c_min_idx[SLOT_COUNT]) : 3'd0;
			any_q        <= c_max_found[SLOT_COUNT];
			in_use_cnt_q <= 4'(c_count[SLOT_COUNT]);
			repl_cnt_q   <= 4'(CNT_W'(SLOT_COUNT) - c_count[SLOT_COUNT]);
		end
	end

	assign out_valid         = out_valid_q;
	assign slot_index        = slot_index_q;
	assign ack_hit           = ack_hit_q;
	assign newest_slot       = newest_q;
	assign oldest_slot       = oldest_q;
	assign any_in_use        = any_q;
	assign in_use_count      = in_use_cnt_q;
	assign replaceable_count = repl_cnt_q;

endmodule

// ===== hw/rtl/ssst_cell.sv =====
// ----------------------------------------------------------------------------
// ssst_cell - one slot of the sample slot table
// Stores one slot's time in seconds and its in-use mark, and folds itself
// into the scan word that walks down the chain one cell per cycle.
// ----------------------------------------------------------------------------
module ssst_cell #(
	parameter int IDX_W    = 3,
	parameter int CNT_W    = 4,
	parameter int CELL_IDX = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sel,
	input  ssst_pkg::cmd_t          cmd,
	input  logic                    prev_vld,
	input  logic                    prev_free_found,
	input  logic [IDX_W-1:0]        prev_free_idx,
	input  logic                    prev_min_found,
	input  logic [IDX_W-1:0]        prev_min_idx,
	input  logic [ssst_pkg::SEC_W-1:0] prev_min_val,
	input  logic                    prev_max_found,
	input  logic [IDX_W-1:0]        prev_max_idx,
	input  logic [ssst_pkg::SEC_W-1:0] prev_max_val,
	input  logic                    prev_match_found,
	input  logic [IDX_W-1:0]        prev_match_idx,
	input  logic [CNT_W-1:0]        prev_count,
	output logic                    next_vld,
	output logic                    next_free_found,
	output logic [IDX_W-1:0]        next_free_idx,
	output logic                    next_min_found,
	output logic [IDX_W-1:0]        next_min_idx,
	output logic [ssst_pkg::SEC_W-1:0] next_min_val,
	output logic                    next_max_found,
	output logic [IDX_W-1:0]        next_max_idx,
	output logic [ssst_pkg::SEC_W-1:0] next_max_val,
	output logic                    next_match_found,
	output logic [IDX_W-1:0]        next_match_idx,
	output logic [CNT_W-1:0]        next_count
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [ssst_pkg::SEC_W-1:0] secs_q;
	logic                       in_use_q;

	logic                       vld_q;
	logic                       free_found_q, min_found_q, max_found_q, match_found_q;
	logic [IDX_W-1:0]           free_idx_q, min_idx_q, max_idx_q, match_idx_q;
	logic [ssst_pkg::SEC_W-1:0] min_val_q, max_val_q;
	logic [CNT_W-1:0]           count_q;

	logic take_free, take_min, take_max, take_match;

	always_comb begin
		take_free  = !prev_free_found && !in_use_q;
		take_min   = in_use_q && (!prev_min_found || (secs_q < prev_min_val));
		take_max   = in_use_q && (!prev_max_found || (secs_q > prev_max_val));
		take_match = !prev_match_found && (secs_q == cmd.secs);
	end

	// Slot contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secs_q   <= '0;
			in_use_q <= 1'b0;
		end else if (cmd.clr_all) begin
			secs_q   <= '0;
			in_use_q <= 1'b0;
		end else if (sel) begin
			if (cmd.load_secs) begin
				secs_q <= cmd.secs;
			end
			in_use_q <= cmd.use_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= prev_vld;
		end
	end

	// Scan word stage; holds its value between passes.
	always_ff @(posedge clk) begin
		if (prev_vld) begin
			free_found_q  <= prev_free_found || take_free;
			free_idx_q    <= take_free ? MY_IDX : prev_free_idx;
			min_found_q   <= prev_min_found || in_use_q;
			min_idx_q     <= take_min ? MY_IDX : prev_min_idx;
			min_val_q     <= take_min ? secs_q : prev_min_val;
			max_found_q   <= prev_max_found || in_use_q;
			max_idx_q     <= take_max ? MY_IDX : prev_max_idx;
			max_val_q     <= take_max ? secs_q : prev_max_val;
			match_found_q <= prev_match_found || take_match;
			match_idx_q   <= take_match ? MY_IDX : prev_match_idx;
			count_q       <= prev_count + CNT_W'(in_use_q);
		end
	end

	assign next_vld         = vld_q;
	assign next_free_found  = free_found_q;
	assign next_free_idx    = free_idx_q;
	assign next_min_found   = min_found_q;
	assign next_min_idx     = min_idx_q;
	assign next_min_val     = min_val_q;
	assign next_max_found   = max_found_q;
	assign next_max_idx     = max_idx_q;
	assign next_max_val     = max_val_q;
	assign next_match_found = match_found_q;
	assign next_match_idx   = match_idx_q;
	assign next_count       = count_q;

endmodule

// ===== tb/timestamped_sample_slot_table_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timestamped_sample_slot_table_top_tb - self-checking bench for the slot table
// Drives command words (insert, acknowledge by time, clear, query) through
// the input handshake and keeps its own copy of the eight slots. A checker
// compares every result word with the report that copy predicts. A short
// directed part covers the corner cases. Random traffic then runs under
// three idling patterns on the two handshakes.
// ----------------------------------------------------------------------------
module timestamped_sample_slot_table_top_tb;

	localparam int SLOTS        = 8;
	// One word is in flight at a time; the end wait gives a generous margin
	// over the time that one word takes.
	localparam int SETTLE_CYCLES = 2 * SLOTS + 6 + 20;
	// Cycles without any word moving on either handshake before the run is declared hung.
	localparam int IDLE_LIMIT   = 2000;
	localparam int MAX_REPORTED = 10;

	// One result word as the block reports it.
	typedef struct packed {
		logic [2:0] slot_index;
		logic       ack_hit;
		logic [2:0] newest_slot;
		logic [2:0] oldest_slot;
		logic       any_in_use;
		logic [3:0] in_use_count;
		logic [3:0] replaceable_count;
	} slot_report_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] func = ssst_pkg::FUNC_QUERY;
	logic [7:0] hour_bcd = '0;
	logic [7:0] minute_bcd = '0;
	logic [7:0] second_bcd = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] slot_index;
	logic       ack_hit;
	logic [2:0] newest_slot;
	logic [2:0] oldest_slot;
	logic       any_in_use;
	logic [3:0] in_use_count;
	logic [3:0] replaceable_count;

	// Percentages of cycles in which the sender and the receiver hold back.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count = 0;
	int quiet_cycles = 0;

	// The bench's own copy of the table: BCD time and in-use mark per slot.
	logic [23:0] table_time [SLOTS];
	bit          table_in_use [SLOTS];

	// Reports predicted for accepted words, oldest first.
	slot_report_t pending_reports [$];

	always #1 clk = ~clk;

	timestamped_sample_slot_table_top #(
		.SLOT_COUNT(SLOTS)
	) DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.func              (func),
		.hour_bcd          (hour_bcd),
		.minute_bcd        (minute_bcd),
		.second_bcd        (second_bcd),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.slot_index        (slot_index),
		.ack_hit           (ack_hit),
		.newest_slot       (newest_slot),
		.oldest_slot       (oldest_slot),
		.any_in_use        (any_in_use),
		.in_use_count      (in_use_count),
		.replaceable_count (replaceable_count)
	);

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Digit pairs are decoded without any range check, so 8'hFF gives 165.
	function automatic int unsigned digit_pair_value(logic [7:0] v);
		return int'(v[7:4]) * 10 + int'(v[3:0]);
	endfunction

	function automatic int unsigned day_seconds(logic [23:0] t);
		return digit_pair_value(t[23:16]) * 3600 + digit_pair_value(t[15:8]) * 60 +
			digit_pair_value(t[7:0]);
	endfunction

	// In-use slot with the greatest or smallest seconds, the first one on
	// ties; -1 when no slot is in use.
	function automatic int extreme_in_use_slot(bit want_greatest);
		int          best;
		int unsigned best_secs;
		int unsigned secs;
		best = -1;
		best_secs = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!table_in_use[i])
				continue;
			secs = day_seconds(table_time[i]);
			if (best < 0 || (want_greatest ? secs > best_secs : secs < best_secs)) begin
				best = i;
				best_secs = secs;
			end
		end
		return best;
	endfunction

	// Applies one command word to the table copy and returns the report the
	// block must give for it.
	function automatic slot_report_t apply_table_command(logic [1:0] op, logic [23:0] t);
		slot_report_t rep;
		int           target;
		int           newest;
		int           oldest;
		int           used;
		int unsigned  wanted;
		rep = '0;
		target = -1;
		used = 0;
		case (op)
			ssst_pkg::FUNC_INSERT: begin
				for (int i = 0; i < SLOTS; i++)
					if (!table_in_use[i] && target < 0)
						target = i;
				// A full table gives up its oldest entry.
				if (target < 0)
					target = extreme_in_use_slot(1'b0);
				if (target < 0)
					target = 0;
				table_time[target] = t;
				table_in_use[target] = 1'b1;
				rep.slot_index = 3'(target);
			end
			ssst_pkg::FUNC_ACK: begin
				// Slots of either status match, and only by decoded seconds.
				wanted = day_seconds(t);
				for (int i = 0; i < SLOTS; i++) begin
					if (!rep.ack_hit && day_seconds(table_time[i]) == wanted) begin
						table_in_use[i] = 1'b0;
						rep.slot_index = 3'(i);
						rep.ack_hit = 1'b1;
					end
				end
			end
			ssst_pkg::FUNC_CLEAR: begin
				for (int i = 0; i < SLOTS; i++) begin
					table_time[i] = '0;
					table_in_use[i] = 1'b0;
				end
			end
			default: begin
			end
		endcase
		for (int i = 0; i < SLOTS; i++)
			used += table_in_use[i] ? 1 : 0;
		newest = extreme_in_use_slot(1'b1);
		oldest = extreme_in_use_slot(1'b0);
		rep.any_in_use = (newest >= 0);
		rep.newest_slot = (newest < 0) ? 3'd0 : 3'(newest);
		rep.oldest_slot = (oldest < 0) ? 3'd0 : 3'(oldest);
		rep.in_use_count = 4'(used);
		rep.replaceable_count = 4'(SLOTS - used);
		return rep;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	function automatic void note_failure(string what);
		fail_count++;
		if (fail_count <= MAX_REPORTED)
			$display("ERROR at %0t ns: %s", $time, what);
	endfunction

	function automatic string report_text(slot_report_t r);
		return $sformatf("slot=%0d hit=%0d newest=%0d oldest=%0d any=%0d used=%0d free=%0d",
			r.slot_index, r.ack_hit, r.newest_slot, r.oldest_slot, r.any_in_use,
			r.in_use_count, r.replaceable_count);
	endfunction

	// Samples the result side at each rising edge. The outputs and out_ready
	// read here still hold their values from before the edge, so the
	// handshake is seen exactly as the block sees it. The receiver's stall
	// pattern is drawn here as well.
	always @(posedge clk) begin
		slot_report_t seen;
		slot_report_t wanted;
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && out_valid && out_ready) begin
			seen = '{slot_index, ack_hit, newest_slot, oldest_slot, any_in_use,
				in_use_count, replaceable_count};
			if (pending_reports.size() == 0) begin
				note_failure({"result word with none expected: ", report_text(seen)});
			end else begin
				wanted = pending_reports.pop_front();
				if (seen.slot_index != wanted.slot_index ||
					seen.ack_hit != wanted.ack_hit ||
					seen.newest_slot != wanted.newest_slot ||
					seen.oldest_slot != wanted.oldest_slot ||
					seen.any_in_use != wanted.any_in_use ||
					seen.in_use_count != wanted.in_use_count ||
					seen.replaceable_count != wanted.replaceable_count)
					note_failure({"mismatch, expected ", report_text(wanted),
						" got ", report_text(seen)});
			end
		end
	end

	// A hung handshake on either side ends the run.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	// Offers one command word and returns at the edge that accepts it. The
	// caller is always sitting on a rising edge, so valid is either kept high
	// for the next word or dropped for a gap, never both in one step.
	task automatic send_command(logic [1:0] op, logic [7:0] hh, logic [7:0] mm,
		logic [7:0] ss);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		hour_bcd <= hh;
		minute_bcd <= mm;
		second_bcd <= ss;
		do
			@(posedge clk);
		while (!in_ready);
		pending_reports.push_back(apply_table_command(op, {hh, mm, ss}));
	endtask

	// Stops offering words and waits until every predicted report is back.
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] to_bcd(int unsigned v);
		return {4'(v / 10), 4'(v % 10)};
	endfunction

	// Mostly legal times of day; a narrow pool that produces equal times and
	// ties; and raw bytes that reach every bit and the non-decimal digits.
	function automatic logic [23:0] random_time_of_day();
		int pick;
		pick = $urandom_range(99);
		if (pick < 55)
			return {to_bcd($urandom_range(23)), to_bcd($urandom_range(59)),
				to_bcd($urandom_range(59))};
		else if (pick < 80)
			return {8'h12, 8'h30, to_bcd($urandom_range(2))};
		else
			return 24'($urandom());
	endfunction

	task automatic send_random_command();
		int          pick;
		logic [1:0]  op;
		logic [23:0] t;
		pick = $urandom_range(99);
		if (pick < 45)
			op = ssst_pkg::FUNC_INSERT;
		else if (pick < 82)
			op = ssst_pkg::FUNC_ACK;
		else if (pick < 96)
			op = ssst_pkg::FUNC_QUERY;
		else
			op = ssst_pkg::FUNC_CLEAR;
		t = random_time_of_day();
		// Most acknowledges name a time that a slot really holds, so hits
		// are common and the table keeps turning over.
		if (op == ssst_pkg::FUNC_ACK && $urandom_range(99) < 75)
			t = table_time[$urandom_range(SLOTS - 1)];
		send_command(op, t[23:16], t[15:8], t[7:0]);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// An empty table reports nothing in use, and a cleared slot still holds
	// 00:00:00, so acknowledging midnight hits slot zero.
	task automatic test_empty_table();
		send_command(ssst_pkg::FUNC_QUERY, 8'h00, 8'h00, 8'h00);
		send_command(ssst_pkg::FUNC_ACK, 8'h00, 8'h00, 8'h00);
	endtask

	// Fills every slot, including the largest raw pattern, a non-decimal
	// digit pattern and two equal times, then inserts into the full table
	// so the oldest entry is overwritten twice.
	task automatic test_insert_and_replace();
		send_command(ssst_pkg::FUNC_INSERT, 8'hFF, 8'hFF, 8'hFF);
		send_command(ssst_pkg::FUNC_INSERT, 8'h00, 8'h00, 8'h00);
		send_command(ssst_pkg::FUNC_INSERT, 8'h23, 8'h59, 8'h59);
		send_command(ssst_pkg::FUNC_INSERT, 8'h00, 8'h00, 8'h0A);
		send_command(ssst_pkg::FUNC_INSERT, 8'h12, 8'h00, 8'h00);
		send_command(ssst_pkg::FUNC_INSERT, 8'h12, 8'h00, 8'h00);
		send_command(ssst_pkg::FUNC_INSERT, 8'h0A, 8'hAA, 8'h55);
		send_command(ssst_pkg::FUNC_INSERT, 8'hF0, 8'h0F, 8'h5A);
		send_command(ssst_pkg::FUNC_INSERT, 8'h06, 8'h00, 8'h00);
		send_command(ssst_pkg::FUNC_INSERT, 8'h06, 8'h00, 8'h01);
	endtask

	// A miss through different digits with equal seconds (0x0A and 0x10 both
	// decode to ten, but the 0x0A entry was replaced), a miss, and a hit on the largest pattern.
	task automatic test_acknowledge();
		send_command(ssst_pkg::FUNC_ACK, 8'h00, 8'h00, 8'h10);
		send_command(ssst_pkg::FUNC_ACK, 8'h12, 8'h34, 8'h56);
		send_command(ssst_pkg::FUNC_ACK, 8'hFF, 8'hFF, 8'hFF);
	endtask

	// Clear empties the table; query ignores its time bytes. Two equal
	// inserts tie for newest and oldest, and a repeated acknowledge keeps
	// matching the first slot even after it became replaceable.
	task automatic test_clear_and_query();
		send_command(ssst_pkg::FUNC_QUERY, 8'hAA, 8'h55, 8'hFF);
		send_command(ssst_pkg::FUNC_CLEAR, 8'h55, 8'hAA, 8'h00);
		send_command(ssst_pkg::FUNC_QUERY, 8'h00, 8'h00, 8'h00);
		send_command(ssst_pkg::FUNC_INSERT, 8'h00, 8'h00, 8'h00);
		send_command(ssst_pkg::FUNC_INSERT, 8'h00, 8'h00, 8'h00);
		send_command(ssst_pkg::FUNC_ACK, 8'h00, 8'h00, 8'h00);
		send_command(ssst_pkg::FUNC_ACK, 8'h00, 8'h00, 8'h00);
		send_command(ssst_pkg::FUNC_CLEAR, 8'h00, 8'h00, 8'h00);
	endtask

	// The sender holds off until every result is back, then resumes, so a
	// word arrives at a block that has been idle for a while.
	task automatic test_drain_pause();
		repeat (6)
			send_random_command();
		wait_until_drained();
		repeat (6)
			send_random_command();
	endtask

	task automatic test_random_traffic(int count, int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count)
			send_random_command();
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			table_time[i] = '0;
			table_in_use[i] = 1'b0;
		end
		send_idle_pct = 12;
		recv_idle_pct = 46;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_insert_and_replace();
		test_acknowledge();
		test_clear_and_query();
		test_drain_pause();
		test_random_traffic(210, 12, 46);
		test_random_traffic(210, 46, 12);
		test_random_traffic(210, 0, 0);

		// Let every outstanding result come back, then give the block time
		// to show any stray result word.
		wait_until_drained();
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
